@@ src/pnps_pkg.sv @@
// Shared types and constants for the packed nibble palette scaler.
package pnps_pkg;

    localparam int ADDR_W  = 16;
    localparam int COLOR_W = 8;
    localparam int INDEX_W = 15;
    localparam int PAIR_W  = 8;
    localparam int CFG_W   = 64;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_PAL_LOW = 2'd1;
    localparam logic [1:0] CFG_PAL_HIGH = 2'd2;

    localparam logic [2:0] MODE_DEFAULT   = 3'd0;
    localparam logic [2:0] MODE_STRETCHED = 3'd1;
    localparam logic [2:0] MODE_ZOOMED    = 3'd2;
    localparam logic [2:0] MODE_SMALL_SQ  = 3'd3;
    localparam logic [2:0] MODE_PICO_SQ   = 3'd4;
    localparam logic [2:0] MODE_SQUARE    = 3'd5;

    localparam logic [2:0] LAST_TWO   = 3'd1;
    localparam logic [2:0] LAST_FOUR  = 3'd3;
    localparam logic [2:0] LAST_EIGHT = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [COLOR_W-1:0] left_color;
        logic [COLOR_W-1:0] right_color;
        logic               wide;
        logic [2:0]         last_k;
    } t_job;

endpackage

@@ src/pnps_in_if.sv @@
// Request channel carrying one framebuffer byte and its index.
interface pnps_in_if;
    import pnps_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] byte_index;
    logic [PAIR_W-1:0]  pixel_pair;

    modport source (output valid, output byte_index, output pixel_pair, input ready);
    modport sink (input valid, input byte_index, input pixel_pair, output ready);
endinterface

@@ src/pnps_out_if.sv @@
// Request channel carrying one draw-buffer write.
interface pnps_out_if;
    import pnps_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  draw_address;
    logic [COLOR_W-1:0] draw_color;
    logic               last_write;

    modport source (output valid, output draw_address, output draw_color,
                    output last_write, input ready);
    modport sink (input valid, input draw_address, input draw_color,
                  input last_write, output ready);
endinterface

@@ src/pnps_locate.sv @@
// Three-stage pipeline: palette lookup, row and column split, window test and base address.
module pnps_locate
    import pnps_pkg::*;
#(
    parameter int RENDER_WIDTH  = 256,
    parameter int RENDER_HEIGHT = 256,
    parameter int SCREEN_BYTES  = 32768
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pnps_in_if.sink            i_pix,
    input  logic [2:0]         i_mode,
    input  logic [CFG_W-1:0]   i_pal_low,
    input  logic [CFG_W-1:0]   i_pal_high,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output t_job               o_job
);

    localparam int HALF   = RENDER_WIDTH / 2;
    localparam int RECIP_K = 25;
    localparam int RECIP  = (2 ** RECIP_K) / HALF;
    localparam int RW     = $clog2(RECIP + 1);
    localparam int QMAX   = ((2 ** INDEX_W) - 1) / HALF;
    localparam int QW     = $clog2(QMAX + 1);
    localparam int CW     = $clog2(HALF);
    localparam int YOFF   = ((RENDER_HEIGHT - 128) * RENDER_WIDTH) / 2;

    localparam logic [RW-1:0]     RECIP_U  = RW'(RECIP);
    localparam logic [ADDR_W-1:0] HALF16   = ADDR_W'(HALF);
    localparam logic [ADDR_W-1:0] W16      = ADDR_W'(RENDER_WIDTH);
    localparam logic [ADDR_W-1:0] OFF_SMALL = ADDR_W'(HALF - 64 + YOFF);
    localparam logic [ADDR_W-1:0] OFF_PICO  = ADDR_W'((RENDER_WIDTH - 128) / 2 + YOFF);
    localparam logic [ADDR_W-1:0] OFF_SQ    = ADDR_W'((RENDER_WIDTH - RENDER_HEIGHT) / 2);
    localparam logic [ADDR_W-1:0] C_STRETCH = ADDR_W'(RENDER_WIDTH / 4);
    localparam logic [ADDR_W-1:0] C_SQUARE  = ADDR_W'(RENDER_HEIGHT / 2);
    localparam logic [19:0] LIM_SCREEN = 20'(SCREEN_BYTES);
    localparam logic [19:0] LIM_ZOOM   = 20'(SCREEN_BYTES / 2);
    localparam logic [19:0] LIM_SMALL  = 20'(HALF * 64);
    localparam logic [19:0] LIM_PICO   = 20'(HALF * 128);

    logic [2*CFG_W-1:0] pal;
    logic [6:0]         lnib_bit;
    logic [6:0]         rnib_bit;
    logic               en1, en2, en3;

    logic                  r_v1;
    logic [INDEX_W-1:0]    r_i1;
    logic [INDEX_W+RW-1:0] r_prod1;
    logic [COLOR_W-1:0]    r_lc1, r_rc1;

    logic [QW-1:0]      q0;
    logic [ADDR_W-1:0]  c0;
    logic               fix;
    logic [QW-1:0]      n_r2;
    logic [ADDR_W-1:0]  n_c2;

    logic               r_v2;
    logic [INDEX_W-1:0] r_i2;
    logic [QW-1:0]      r_r2;
    logic [CW-1:0]      r_c2;
    logic [COLOR_W-1:0] r_lc2, r_rc2;

    logic [ADDR_W-1:0]  rw;
    logic [ADDR_W-1:0]  c4;
    logic [ADDR_W-1:0]  i2x;
    logic [ADDR_W-1:0]  c16;
    logic [19:0]        i20;
    logic               show;
    t_job               n_job;

    logic               r_v3;
    t_job               r_job;

    assign pal      = {i_pal_high, i_pal_low};
    assign lnib_bit = {i_pix.pixel_pair[7:4], 3'b000};
    assign rnib_bit = {i_pix.pixel_pair[3:0], 3'b000};

    assign en3 = !r_v3 || i_job_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_pix.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_i1    <= i_pix.byte_index;
            r_prod1 <= (INDEX_W+RW)'(i_pix.byte_index) * (INDEX_W+RW)'(RECIP_U);
            r_lc1   <= pal[lnib_bit +: COLOR_W];
            r_rc1   <= pal[rnib_bit +: COLOR_W];
        end
    end

    // The reciprocal estimate is low by at most one, so one correction step suffices.
    assign q0   = r_prod1[RECIP_K +: QW];
    assign c0   = ADDR_W'(r_i1) - ADDR_W'(ADDR_W'(q0) * HALF16);
    assign fix  = c0 >= HALF16;
    assign n_r2 = fix ? q0 + QW'(1) : q0;
    assign n_c2 = fix ? c0 - HALF16 : c0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_i2  <= r_i1;
            r_r2  <= n_r2;
            r_c2  <= n_c2[CW-1:0];
            r_lc2 <= r_lc1;
            r_rc2 <= r_rc1;
        end
    end

    assign rw  = ADDR_W'(r_r2) * W16;
    assign c16 = ADDR_W'(r_c2);
    assign c4  = {c16[ADDR_W-3:0], 2'b00};
    assign i2x = {r_i2, 1'b0};
    assign i20 = 20'(r_i2);

    always_comb begin
        n_job.left_color  = r_lc2;
        n_job.right_color = r_rc2;
        n_job.wide        = 1'b0;
        n_job.last_k      = LAST_TWO;
        n_job.base        = i2x;
        show              = i20 < LIM_SCREEN;
        case (i_mode)
            MODE_STRETCHED: begin
                show         = show && (c16 < C_STRETCH);
                n_job.wide   = 1'b1;
                n_job.last_k = LAST_FOUR;
                n_job.base   = rw + c4;
            end
            MODE_ZOOMED: begin
                show         = show && (c16 < C_STRETCH) && (i20 < LIM_ZOOM);
                n_job.wide   = 1'b1;
                n_job.last_k = LAST_EIGHT;
                n_job.base   = {rw[ADDR_W-2:0], 1'b0} + c4;
            end
            MODE_SMALL_SQ: begin
                show         = show && (c16 < 16'd32) && (i20 < LIM_SMALL);
                n_job.wide   = 1'b1;
                n_job.last_k = LAST_EIGHT;
                n_job.base   = OFF_SMALL + {rw[ADDR_W-2:0], 1'b0} + c4;
            end
            MODE_PICO_SQ: begin
                show         = show && (c16 < 16'd64) && (i20 < LIM_PICO);
                n_job.base   = OFF_PICO + i2x;
            end
            MODE_SQUARE: begin
                show         = show && (c16 < C_SQUARE);
                n_job.base   = OFF_SQ + i2x;
            end
            default: begin
                n_job.base   = i2x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2 && show;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_v3;
    assign o_job       = r_job;

endmodule

@@ src/pnps_expand.sv @@
// Expands one placed byte into two, four or eight draw writes through an output register.
module pnps_expand
    import pnps_pkg::*;
#(
    parameter int RENDER_WIDTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    pnps_out_if.source  o_wr
);

    localparam logic [ADDR_W-1:0] W16 = ADDR_W'(RENDER_WIDTH);

    logic               r_e_valid;
    t_job               r_e_job;
    logic [2:0]         r_e_k;
    logic               out_free;
    logic               emit;
    logic               e_last;
    logic               take;
    logic [ADDR_W-1:0]  n_addr;
    logic [COLOR_W-1:0] n_color;

    logic               r_o_valid;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [COLOR_W-1:0] r_o_color;
    logic               r_o_last;

    assign out_free    = !r_o_valid || o_wr.ready;
    assign emit        = r_e_valid && out_free;
    assign e_last      = r_e_k == r_e_job.last_k;
    assign take        = !r_e_valid || (emit && e_last);
    assign o_job_ready = take;

    always_comb begin
        if (r_e_job.wide) begin
            n_addr  = r_e_job.base + (r_e_k[2] ? W16 : '0) + ADDR_W'(r_e_k[1:0]);
            n_color = r_e_k[1] ? r_e_job.right_color : r_e_job.left_color;
        end else begin
            n_addr  = r_e_job.base + ADDR_W'(r_e_k[0]);
            n_color = r_e_k[0] ? r_e_job.right_color : r_e_job.left_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_e_k     <= '0;
        end else if (take) begin
            r_e_valid <= i_job_valid;
            r_e_k     <= '0;
        end else if (emit) begin
            r_e_k <= r_e_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_e_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_addr  <= n_addr;
            r_o_color <= n_color;
            r_o_last  <= e_last;
        end
    end

    assign o_wr.valid        = r_o_valid;
    assign o_wr.draw_address = r_o_addr;
    assign o_wr.draw_color   = r_o_color;
    assign o_wr.last_write   = r_o_last;

endmodule

@@ src/packed_nibble_palette_scaler.sv @@
// Top level of the packed nibble palette scaler with its configuration registers.
//
//  Channel   Dir  Handshake      Payload
//  i_pix     in   valid/ready    byte_index[14:0], pixel_pair[7:0]
//  o_wr      out  valid/ready    draw_address[15:0], draw_color[7:0], last_write
//  i_cfg_*   in   write enable   i_cfg_index[1:0], i_cfg_data[63:0]
//
// A request passes three pipeline stages and then the expander's job and output
// registers before its first write appears.
// The expander issues one write per cycle while the output is not stalled: a byte makes two writes
// in the default, pico and square modes, four when stretched and eight in the zoomed and small square modes.
// Bytes outside the selected window leave the pipeline without any write.
// Reset is synchronous and clears all valid bits and the configuration registers, not the data registers.
// A stall on the output holds every stage in place; nothing is lost or repeated.
module packed_nibble_palette_scaler
    import pnps_pkg::*;
#(
    parameter int RENDER_WIDTH  = 256,
    parameter int RENDER_HEIGHT = 256,
    parameter int SCREEN_BYTES  = 32768
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pnps_in_if.sink          i_pix,
    pnps_out_if.source       o_wr,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [2:0]       r_mode;
    logic [CFG_W-1:0] r_pal_low;
    logic [CFG_W-1:0] r_pal_high;
    logic             job_valid;
    logic             job_ready;
    t_job             job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_DEFAULT;
            r_pal_low  <= '0;
            r_pal_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:     r_mode     <= i_cfg_data[2:0];
                CFG_PAL_LOW:  r_pal_low  <= i_cfg_data;
                CFG_PAL_HIGH: r_pal_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pnps_locate #(
        .RENDER_WIDTH  (RENDER_WIDTH),
        .RENDER_HEIGHT (RENDER_HEIGHT),
        .SCREEN_BYTES  (SCREEN_BYTES)
    ) u_locate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_mode      (r_mode),
        .i_pal_low   (r_pal_low),
        .i_pal_high  (r_pal_high),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    pnps_expand #(
        .RENDER_WIDTH (RENDER_WIDTH)
    ) u_expand (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_wr        (o_wr)
    );

endmodule
